/* rtl/twtc_pkg.sv */
`default_nettype none
package twtc_pkg;

	localparam int unsigned CoordW = 24;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned SqW    = 50;
	localparam int unsigned RootW  = 25;

	typedef struct packed {
		logic [23:0] x_pos;
		logic [23:0] y_pos;
		logic [23:0] open_at;
		logic [23:0] close_at;
		logic [23:0] service_len;
		logic        last_node;
	} in_item_t;

	typedef struct packed {
		logic        still_feasible;
		logic [31:0] finish_time;
		logic        route_done;
		logic        node_skipped;
	} out_item_t;

	typedef enum logic [2:0] {
		REG_DEPOT_X       = 3'd0,
		REG_DEPOT_Y       = 3'd1,
		REG_DEPOT_OPEN    = 3'd2,
		REG_DEPOT_SERVICE = 3'd3,
		REG_HORIZON       = 3'd4,
		REG_LENIENT       = 3'd5
	} reg_idx_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [23:0] abs_diff(input logic [23:0] a, input logic [23:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

/* rtl/twtc_isqrt.sv */
`default_nettype none
module twtc_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [twtc_pkg::SqW-1:0]  radicand,
	output logic                           done,
	output logic [twtc_pkg::RootW-1:0]     root
);
	import twtc_pkg::*;

	localparam int unsigned Steps = RootW;
	localparam int unsigned CntW  = $clog2(Steps + 1);

	logic [SqW-1:0]   rad_q;
	logic [RootW+1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;

	logic [RootW+1:0] trial;
	logic [RootW+1:0] rem_sh;

	// one result bit per cycle, two radicand bits shifted in
	assign rem_sh = {rem_q[RootW-1:0], rad_q[SqW-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SqW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule
`default_nettype wire

/* rtl/twtc_queue.sv */
`default_nettype none
module twtc_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire twtc_pkg::in_item_t   push_data,
	output logic                      full,
	input  wire logic                 pop,
	output twtc_pkg::in_item_t        pop_data,
	output logic                      not_empty
);
	import twtc_pkg::*;

	in_item_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule
`default_nettype wire

/* rtl/twtc_back.sv */
`default_nettype none
module twtc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire twtc_pkg::in_item_t item,
	output logic                    item_pop,
	input  wire logic [23:0]        depot_x,
	input  wire logic [23:0]        depot_y,
	input  wire logic [23:0]        depot_open,
	input  wire logic [23:0]        depot_service,
	input  wire logic [23:0]        horizon,
	input  wire logic               lenient_mode,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output twtc_pkg::out_item_t     res
);
	import twtc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SQ1   = 7'b0000010,
		ST_SQ2   = 7'b0000100,
		ST_NODE  = 7'b0001000,
		ST_SQ3   = 7'b0010000,
		ST_RET   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t      state_q;
	in_item_t    item_q;
	logic [31:0] time_q;
	logic [23:0] pos_x_q, pos_y_q;
	logic        failed_q, at_depot_q, skipped_q;
	logic [24:0] d_node_q, d_back_q;
	logic [47:0] sqx_q, sqy_q;
	logic        pre_q, start_q;

	logic [23:0] cx, cy, ax, ay, bx, by, dx, dy;
	logic        sq_start, sq_done;
	logic [SqW-1:0]   radicand;
	logic [RootW-1:0] root;

	logic [31:0] arrive, fin, back, r_arrive, r_fin;

	assign cx = at_depot_q ? depot_x : pos_x_q;
	assign cy = at_depot_q ? depot_y : pos_y_q;

	// operand select for the shared distance unit
	always_comb begin
		ax = cx; ay = cy; bx = item_q.x_pos; by = item_q.y_pos;
		unique case (state_q)
			ST_SQ2: begin
				ax = item_q.x_pos; ay = item_q.y_pos; bx = depot_x; by = depot_y;
			end
			ST_SQ3: begin
				bx = depot_x; by = depot_y;
			end
			default: ;
		endcase
	end

	assign dx = abs_diff(ax, bx);
	assign dy = abs_diff(ay, by);

	// register both squares from the selected operands; the start strobe is registered alongside them
	assign radicand = {2'b00, sqx_q} + {2'b00, sqy_q};
	assign sq_start = start_q;

	twtc_isqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(radicand),
		.done    (sq_done),
		.root    (root)
	);

	assign arrive   = sat_add(time_q, {7'd0, d_node_q});
	assign fin      = sat_add((arrive > {8'd0, item_q.open_at}) ? arrive
				: {8'd0, item_q.open_at}, {8'd0, item_q.service_len});
	assign back     = sat_add(fin, {7'd0, d_back_q});
	assign r_arrive = sat_add(time_q, {7'd0, d_node_q});
	assign r_fin    = sat_add((r_arrive > {8'd0, depot_open}) ? r_arrive
				: {8'd0, depot_open}, {8'd0, depot_service});

	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign res_valid = state_q == ST_OUT;
	assign res.still_feasible = ~failed_q;
	assign res.finish_time    = time_q;
	assign res.route_done     = item_q.last_node;
	assign res.node_skipped   = skipped_q;

	always_ff @(posedge clk) begin
		sqx_q <= dx * dx;
		sqy_q <= dy * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			time_q     <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			failed_q   <= 1'b0;
			at_depot_q <= 1'b1;
			skipped_q  <= 1'b0;
			pre_q      <= 1'b0;
			start_q    <= 1'b0;
			d_node_q   <= '0;
			d_back_q   <= '0;
			item_q     <= '0;
		end else begin
			pre_q   <= 1'b0;
			start_q <= pre_q;
			unique case (state_q)
				ST_IDLE: begin
					skipped_q <= 1'b0;
					if (item_valid) begin
						item_q <= item;
						if (failed_q) begin
							state_q <= ST_OUT;
						end else begin
							pre_q   <= 1'b1;
							state_q <= ST_SQ1;
						end
					end
				end
				ST_SQ1: if (sq_done) begin
					d_node_q <= root;
					pre_q    <= 1'b1;
					state_q  <= ST_SQ2;
				end
				ST_SQ2: if (sq_done) begin
					d_back_q <= root;
					state_q  <= ST_NODE;
				end
				ST_NODE: begin
					if (back > {8'd0, horizon}) begin
						failed_q <= 1'b1;
						state_q  <= ST_OUT;
					end else if (arrive > {8'd0, item_q.close_at}) begin
						if (lenient_mode) skipped_q <= 1'b1;
						else failed_q <= 1'b1;
						if (lenient_mode && item_q.last_node) begin
							pre_q   <= 1'b1;
							state_q <= ST_SQ3;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						time_q     <= fin;
						pos_x_q    <= item_q.x_pos;
						pos_y_q    <= item_q.y_pos;
						at_depot_q <= 1'b0;
						if (item_q.last_node) begin
							// return distance equals the node-to-depot leg
							d_node_q <= d_back_q;
							state_q  <= ST_RET;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SQ3: if (sq_done) begin
					d_node_q <= root;
					state_q  <= ST_RET;
				end
				ST_RET: begin
					if (r_fin > {8'd0, horizon}) failed_q <= 1'b1;
					else time_q <= r_fin;
					state_q <= ST_OUT;
				end
				ST_OUT: if (!res_stall) begin
					state_q <= ST_IDLE;
					if (item_q.last_node) begin
						time_q     <= '0;
						failed_q   <= 1'b0;
						at_depot_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> state_q == ST_IDLE)
		else $error("pop outside idle");
	a_skip_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.node_skipped && !res.route_done |-> res.still_feasible)
		else $error("skip with failure");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(time_q))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

/* rtl/twtc_front.sv */
`default_nettype none
module twtc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [23:0]         cfg_data,
	output logic                     cfg_ready,
	input  wire logic                queue_full,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     push,
	output logic [23:0]              depot_x,
	output logic [23:0]              depot_y,
	output logic [23:0]              depot_open,
	output logic [23:0]              depot_service,
	output logic [23:0]              horizon,
	output logic                     lenient_mode
);
	import twtc_pkg::*;

	assign cfg_ready = 1'b1;
	assign in_stall  = queue_full;
	assign push      = in_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depot_x       <= '0;
			depot_y       <= '0;
			depot_open    <= '0;
			depot_service <= '0;
			horizon       <= 24'hFF_FFFF;
			lenient_mode  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEPOT_X:       depot_x       <= cfg_data;
				REG_DEPOT_Y:       depot_y       <= cfg_data;
				REG_DEPOT_OPEN:    depot_open    <= cfg_data;
				REG_DEPOT_SERVICE: depot_service <= cfg_data;
				REG_HORIZON:       horizon       <= cfg_data;
				REG_LENIENT:       lenient_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/time_window_tour_check.sv */
`default_nettype none
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_data (in_item_t)
// out     | out | out_valid/out_stall| out_data (out_item_t)
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// A node goes from queue pop through two 25-step roots on one shared unit, each behind
// a square register and a start register, then check and output. Closing a route adds
// a return state; a skipped last node needs a third root; a node of a failed route goes
// straight to output. An output stall holds the result; the next node is popped after.
// A two-entry queue between input and the check engine absorbs stalls.
// Reset is asynchronous, active low; configuration returns to its defaults.
module time_window_tour_check (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire twtc_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output twtc_pkg::out_item_t       out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [23:0]          cfg_data
);
	import twtc_pkg::*;

	logic        full, push, pop, nempty;
	in_item_t    qdata;
	logic [23:0] dx, dy, dop, dsv, hz;
	logic        len;

	twtc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cfg_ready(cfg_ready), .queue_full(full), .in_valid(in_valid),
		.in_stall(in_stall), .push(push),
		.depot_x(dx), .depot_y(dy), .depot_open(dop), .depot_service(dsv),
		.horizon(hz), .lenient_mode(len)
	);

	twtc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(in_data), .full(full),
		.pop(pop), .pop_data(qdata), .not_empty(nempty)
	);

	twtc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(nempty), .item(qdata), .item_pop(pop),
		.depot_x(dx), .depot_y(dy), .depot_open(dop), .depot_service(dsv),
		.horizon(hz), .lenient_mode(len),
		.res_valid(out_valid), .res_stall(out_stall), .res(out_data)
	);
endmodule
`default_nettype wire

/* sim/time_window_tour_check_tb.sv */
`default_nettype none
module time_window_tour_check_tb;
	import twtc_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;

	time_window_tour_check uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int WATCHDOG_LIMIT = 200000;

	// shadow of configuration and route state
	logic [23:0] dep_x, dep_y, dep_open, dep_svc, hzn;
	logic        lenient;
	logic [31:0] route_time;
	logic [23:0] route_x, route_y;
	logic        route_failed, route_at_depot;

	out_item_t verdicts_pending[$];
	int mismatches;
	int nodes_sent, results_seen, routes_closed, skips_seen, fails_seen;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] root_of(input logic [63:0] v);
		logic [63:0] rem, root, bit_w;
		rem = v;
		root = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > rem) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (rem >= root + bit_w) begin
				rem = rem - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root[31:0];
	endfunction

	function automatic logic [31:0] leg_length(input logic [23:0] ax, input logic [23:0] ay,
			input logic [23:0] bx, input logic [23:0] by);
		logic [63:0] dx, dy;
		dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
		dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
		return root_of(dx * dx + dy * dy);
	endfunction

	function automatic void reset_route();
		route_time = 0;
		route_x = 0;
		route_y = 0;
		route_failed = 1'b0;
		route_at_depot = 1'b1;
	endfunction

	function automatic out_item_t visit_node(input in_item_t n);
		out_item_t r;
		logic [31:0] arrive, fin, back;
		logic [23:0] cx, cy;
		logic skipped;
		skipped = 1'b0;
		cx = route_at_depot ? dep_x : route_x;
		cy = route_at_depot ? dep_y : route_y;
		if (!route_failed) begin
			arrive = add_sat(route_time, leg_length(cx, cy, n.x_pos, n.y_pos));
			fin = add_sat((arrive > {8'd0, n.open_at}) ? arrive : {8'd0, n.open_at},
				{8'd0, n.service_len});
			back = add_sat(fin, leg_length(n.x_pos, n.y_pos, dep_x, dep_y));
			if (back > {8'd0, hzn}) begin
				route_failed = 1'b1;
			end else if (arrive > {8'd0, n.close_at}) begin
				if (lenient) skipped = 1'b1;
				else route_failed = 1'b1;
			end else begin
				route_time = fin;
				route_x = n.x_pos;
				route_y = n.y_pos;
				route_at_depot = 1'b0;
				cx = n.x_pos;
				cy = n.y_pos;
			end
		end
		if (n.last_node && !route_failed) begin
			arrive = add_sat(route_time, leg_length(cx, cy, dep_x, dep_y));
			fin = add_sat((arrive > {8'd0, dep_open}) ? arrive : {8'd0, dep_open},
				{8'd0, dep_svc});
			if (fin > {8'd0, hzn}) route_failed = 1'b1;
			else route_time = fin;
		end
		r.still_feasible = !route_failed;
		r.finish_time = route_time;
		r.route_done = n.last_node;
		r.node_skipped = skipped;
		if (n.last_node) reset_route();
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	task automatic send_node(input in_item_t n);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		verdicts_pending.insert(verdicts_pending.size(), visit_node(n));
		nodes_sent++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DEPOT_X:       dep_x = val;
			REG_DEPOT_Y:       dep_y = val;
			REG_DEPOT_OPEN:    dep_open = val;
			REG_DEPOT_SERVICE: dep_svc = val;
			REG_HORIZON:       hzn = val;
			REG_LENIENT:       lenient = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts_pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_config(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] op, input logic [23:0] sv, input logic [23:0] h,
			input logic len);
		drain();
		write_reg(REG_DEPOT_X, x);
		write_reg(REG_DEPOT_Y, y);
		write_reg(REG_DEPOT_OPEN, op);
		write_reg(REG_DEPOT_SERVICE, sv);
		write_reg(REG_HORIZON, h);
		write_reg(REG_LENIENT, len);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t make_node(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] op, input logic [23:0] cl, input logic [23:0] sv,
			input logic last);
		in_item_t n;
		n.x_pos = x;
		n.y_pos = y;
		n.open_at = op;
		n.close_at = cl;
		n.service_len = sv;
		n.last_node = last;
		return n;
	endfunction

	// node near the depot with a window that usually fits
	function automatic in_item_t plausible_node(input int spread, input logic last);
		logic [23:0] x, y, op;
		x = 24'(int'(dep_x) + $urandom_range(0, spread) - spread / 2);
		y = 24'(int'(dep_y) + $urandom_range(0, spread) - spread / 2);
		op = 24'(route_time) + 24'($urandom_range(0, spread));
		return make_node(x, y, op, op + 24'($urandom_range(0, 4 * spread)),
			24'($urandom_range(0, spread / 4)), last);
	endfunction

	function automatic in_item_t noise_node();
		return make_node(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom), $urandom_range(0, 3) == 0);
	endfunction

	task automatic test_defaults();
		// reset values: depot at origin, full horizon, strict
		send_node(make_node(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1));
		send_node(make_node(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
		send_node(make_node(24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 1'b1));
	endtask

	task automatic test_directed();
		load_config(24'h001000, 24'h002000, 24'h000100, 24'h000080, 24'h080000, 1'b0);
		send_node(make_node(24'h001300, 24'h002400, 24'h000200, 24'h004000, 24'h000100, 1'b0));
		send_node(make_node(24'h001800, 24'h002000, 24'h000000, 24'h010000, 24'h000040, 1'b1));
		// strict late node fails, later nodes ignored
		send_node(make_node(24'h005000, 24'h002000, 24'h000000, 24'h000001, 24'h0, 1'b0));
		send_node(make_node(24'h001000, 24'h002000, 24'h0, 24'hFFFFFF, 24'h0, 1'b1));
		// horizon miss
		send_node(make_node(24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF, 24'h0, 1'b1));
		// depot return over horizon: service huge
		load_config(24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		send_node(make_node(24'h000100, 24'h0, 24'h0, 24'hFFFFFF, 24'h0, 1'b1));
		// lenient skip then continue
		load_config(24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 1'b1);
		send_node(make_node(24'h008000, 24'h0, 24'h0, 24'h000010, 24'h0, 1'b0));
		send_node(make_node(24'h000100, 24'h000100, 24'h000400, 24'h000800, 24'h10, 1'b0));
		send_node(make_node(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1));
		// horizon zero: anything away from the depot fails
		load_config(24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b0);
		send_node(make_node(24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b1));
		send_node(make_node(24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'h0, 1'b1));
	endtask

	task automatic test_random_routes();
		int spread, len;
		for (int phase = 0; phase < 8; phase++) begin
			load_config(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
				24'($urandom_range(0, 24'h4000)), 24'($urandom_range(0, 24'h400)),
				(phase == 0) ? 24'hFFFFFF : 24'($urandom_range(24'h8000, 24'hFFFFFF)),
				phase[0]);
			for (int r = 0; r < 62; r++) begin
				spread = ($urandom_range(0, 9) == 0) ? 24'h40000 : 24'h2000;
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0)
						send_node(noise_node());
					else
						send_node(plausible_node(spread, k == len - 1));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEPOT_X;
		cfg_data = '0;
		dep_x = 0; dep_y = 0; dep_open = 0; dep_svc = 0;
		hzn = 24'hFFFFFF;
		lenient = 1'b0;
		reset_route();
		mismatches = 0;
		nodes_sent = 0; results_seen = 0; routes_closed = 0;
		skips_seen = 0; fails_seen = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_directed();
		test_random_routes();
		drain();
		$display("Checked %0d nodes, %0d results, %0d closed routes", nodes_sent,
			results_seen, routes_closed);
		$display("Lenient skips %0d, infeasible results %0d", skips_seen, fails_seen);
		if (mismatches == 0 && verdicts_pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// receiver stall: runs of random length
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			run = gap_len();
			if (run != 0) begin
				out_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (verdicts_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %p", out_data);
			end else begin
				want = verdicts_pending.pop_front();
				if (out_data.route_done) routes_closed++;
				if (out_data.node_skipped) skips_seen++;
				if (!out_data.still_feasible) fails_seen++;
				if (out_data.still_feasible !== want.still_feasible ||
						out_data.finish_time !== want.finish_time ||
						out_data.route_done !== want.route_done ||
						out_data.node_skipped !== want.node_skipped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, out_data);
				end
			end
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready) || verdicts_pending.size() == 0) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/twtc_pkg.sv
rtl/twtc_isqrt.sv
rtl/twtc_queue.sv
rtl/twtc_back.sv
rtl/twtc_front.sv
rtl/time_window_tour_check.sv
sim/time_window_tour_check_tb.sv
